// File: design/ctsg_pkg.sv
// Shared types and constants for the climb step throttle governor.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package ctsg_pkg;

	// Item kinds, encoded as on the mode input.
	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_PRESS  = 2'd1;
	localparam logic [1:0] MODE_CANCEL = 2'd2;
	localparam logic [1:0] MODE_RESET  = 2'd3;

	// Climb modes.
	localparam logic [1:0] CLIMB_OFF  = 2'd0;
	localparam logic [1:0] CLIMB_STEP = 2'd1;
	localparam logic [1:0] CLIMB_CONT = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_GRAVITY   = 3'd0;
	localparam logic [2:0] REG_DRAG      = 3'd1;
	localparam logic [2:0] REG_MASS      = 3'd2;
	localparam logic [2:0] REG_LAG       = 3'd3;
	localparam logic [2:0] REG_DTAP      = 3'd4;
	localparam logic [2:0] REG_TIMEOUT   = 3'd5;
	localparam logic [2:0] REG_STEP      = 3'd6;

	// Configuration reset values.
	localparam logic [30:0] GRAVITY_RST = 31'd642908;
	localparam logic [30:0] MASS_RST    = 31'd65536;
	localparam logic [15:0] DTAP_RST    = 16'd350;
	localparam logic [15:0] TIMEOUT_RST = 16'd2000;
	localparam logic [30:0] STEP_RST    = 31'd65536;

	typedef struct packed {
		logic [30:0] gravity;
		logic [30:0] drag_coefficient;
		logic [30:0] body_mass;
		logic [30:0] motor_lag;
		logic [15:0] double_tap_ms;
		logic [15:0] step_timeout_ms;
		logic [30:0] step_height;
	} cfg_t;

	// One classified request as held in the queue.
	typedef struct packed {
		logic [1:0]         kind;
		logic [31:0]        time_ms;
		logic signed [31:0] altitude;
		logic signed [31:0] vertical_speed;
		logic               vs_pos;
	} item_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic       throttle;
		logic [1:0] climb_state;
	} result_t;

endpackage

`default_nettype wire

// File: design/ctsg_front.sv
// Front end: accepts requests, classifies them and keeps them in a two-entry queue.
// Depends on ctsg_pkg.
`default_nettype none

module ctsg_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [1:0]          mode,
	input  wire  [31:0]         time_ms,
	input  wire  signed [31:0]  altitude,
	input  wire  signed [31:0]  vertical_speed,
	output logic                q_valid,
	output ctsg_pkg::item_t     q_head,
	input  wire                 q_pop
);

	ctsg_pkg::item_t entry_q [2];
	ctsg_pkg::item_t item_in;
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;

	// Classify the incoming request.
	always_comb begin
		item_in.kind           = mode;
		item_in.time_ms        = time_ms;
		item_in.altitude       = altitude;
		item_in.vertical_speed = vertical_speed;
		item_in.vs_pos         = !vertical_speed[31] && (vertical_speed != 32'sd0);
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_head   = entry_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item_in;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/ctsg_div.sv
// Restoring divider for 64-bit unsigned operands, one quotient bit per cycle.
// Depends on ctsg_pkg for the request and response structs.
`default_nettype none

module ctsg_div (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ctsg_pkg::div_req_t  req,
	output ctsg_pkg::div_rsp_t  rsp
);

	logic [63:0] rem_q;
	logic [63:0] dvd_q;
	logic [63:0] divisor_q;
	logic [6:0]  cnt_q;
	logic        done_q;
	logic [64:0] trial;
	logic [64:0] diff;
	logic        ge;

	// One restoring step.
	always_comb begin
		trial = {rem_q, dvd_q[63]};
		ge    = (trial >= {1'b0, divisor_q});
		diff  = trial - {1'b0, divisor_q};
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= 64'd0;
			dvd_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (cnt_q != 7'd0) begin
			rem_q <= ge ? diff[63:0] : trial[63:0];
			dvd_q <= {dvd_q[62:0], ge};
		end
	end

	// Iteration count and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 7'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 7'd1);
			if (req.start) begin
				cnt_q <= 7'd64;
			end else if (cnt_q != 7'd0) begin
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

`default_nettype wire

// File: design/ctsg_back.sv
// Back end: climb state, press handling and the step-climb stopping test.
// Depends on ctsg_pkg and ctsg_div; a shared 32x32 multiplier sits in this module.
`default_nettype none

module ctsg_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ctsg_pkg::cfg_t      cfg,
	input  wire                 q_valid,
	input  ctsg_pkg::item_t     q_head,
	output logic                q_pop,
	output logic                res_valid,
	output ctsg_pkg::result_t   res,
	input  wire                 res_ready
);

	localparam logic [3:0] S_IDLE       = 4'd0;
	localparam logic [3:0] S_EXEC       = 4'd1;
	localparam logic [3:0] S_MDRAG      = 4'd2;
	localparam logic [3:0] S_DDRAG_GO   = 4'd3;
	localparam logic [3:0] S_DDRAG_WAIT = 4'd4;
	localparam logic [3:0] S_MSQ        = 4'd5;
	localparam logic [3:0] S_DCOAST_GO  = 4'd6;
	localparam logic [3:0] S_DCOAST_WT  = 4'd7;
	localparam logic [3:0] S_MLAG       = 4'd8;
	localparam logic [3:0] S_CMP        = 4'd9;
	localparam logic [3:0] S_RESULT     = 4'd10;

	logic [3:0]         state_q;
	ctsg_pkg::item_t    item_q;
	logic [1:0]         climb_mode_q;
	logic [31:0]        last_press_q;
	logic               press_seen_q;
	logic signed [31:0] target_q;
	logic [31:0]        deadline_q;
	logic               thr_q;
	logic [31:0]        rem_q;
	logic [63:0]        prod_q;
	logic [63:0]        decel_q;
	logic [31:0]        coast_q;

	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [31:0]        since;
	logic               dbl;
	logic [32:0]        tgt_sum;
	logic [31:0]        tgt_sat;
	logic [31:0]        late;
	logic               expired;
	logic [32:0]        remaining;
	logic [46:0]        stop_sum;
	ctsg_pkg::div_req_t div_req;
	ctsg_pkg::div_rsp_t div_rsp;

	ctsg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Press, deadline and distance arithmetic on the current request.
	always_comb begin
		since     = item_q.time_ms - last_press_q;
		dbl       = press_seen_q && (since <= {16'd0, cfg.double_tap_ms});
		tgt_sum   = {item_q.altitude[31], item_q.altitude} + {2'b00, cfg.step_height};
		tgt_sat   = (!tgt_sum[32] && tgt_sum[31]) ? 32'h7FFF_FFFF : tgt_sum[31:0];
		late      = item_q.time_ms - deadline_q;
		expired   = !late[31] && (late != 32'd0);
		remaining = {target_q[31], target_q} - {item_q.altitude[31], item_q.altitude};
		stop_sum  = {15'd0, coast_q} + {1'b0, prod_q[61:16]};
	end

	// Shared multiplier operands; the speed is positive wherever it is used.
	always_comb begin
		mul_a = item_q.vertical_speed;
		unique case (state_q)
			S_MDRAG: mul_b = {1'b0, cfg.drag_coefficient};
			S_MSQ:   mul_b = item_q.vertical_speed;
			default: mul_b = {1'b0, cfg.motor_lag};
		endcase
	end

	// Divider requests.
	always_comb begin
		div_req.start    = (state_q == S_DDRAG_GO) || (state_q == S_DCOAST_GO);
		div_req.dividend = prod_q;
		if (state_q == S_DDRAG_GO) begin
			div_req.divisor = {32'd0, cfg.body_mass, 1'b0};
		end else begin
			div_req.divisor = {decel_q[62:0], 1'b0};
		end
	end

	assign q_pop           = (state_q == S_IDLE) && q_valid;
	assign res_valid       = (state_q == S_RESULT);
	assign res.throttle    = thr_q;
	assign res.climb_state = climb_mode_q;

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_head;
		end
		if (state_q == S_MDRAG || state_q == S_MSQ || state_q == S_MLAG) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == S_EXEC) begin
			rem_q   <= remaining[31:0];
			decel_q <= {33'd0, cfg.gravity};
		end
		if (state_q == S_DDRAG_WAIT && div_rsp.done) begin
			decel_q <= {33'd0, cfg.gravity} + div_rsp.quotient;
		end
		if (state_q == S_MSQ) begin
			coast_q <= 32'd0;
		end
		if (state_q == S_DCOAST_WT && div_rsp.done) begin
			coast_q <= (div_rsp.quotient[63:32] != 32'd0) ? 32'hFFFF_FFFF
				: div_rsp.quotient[31:0];
		end
		if (state_q == S_EXEC && item_q.kind == ctsg_pkg::MODE_PRESS && !dbl
				&& climb_mode_q != ctsg_pkg::CLIMB_CONT) begin
			target_q   <= tgt_sat;
			deadline_q <= item_q.time_ms + {16'd0, cfg.step_timeout_ms};
		end
	end

	// Sequencer and climb state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			climb_mode_q <= ctsg_pkg::CLIMB_OFF;
			last_press_q <= 32'd0;
			press_seen_q <= 1'b0;
			thr_q        <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					thr_q   <= 1'b0;
					state_q <= S_RESULT;
					unique case (item_q.kind)
						ctsg_pkg::MODE_PRESS: begin
							last_press_q <= item_q.time_ms;
							press_seen_q <= 1'b1;
							if (dbl) begin
								climb_mode_q <= ctsg_pkg::CLIMB_CONT;
							end else if (climb_mode_q == ctsg_pkg::CLIMB_CONT) begin
								climb_mode_q <= ctsg_pkg::CLIMB_OFF;
							end else begin
								climb_mode_q <= ctsg_pkg::CLIMB_STEP;
							end
						end
						ctsg_pkg::MODE_CANCEL: begin
							climb_mode_q <= ctsg_pkg::CLIMB_OFF;
						end
						ctsg_pkg::MODE_RESET: begin
							climb_mode_q <= ctsg_pkg::CLIMB_OFF;
							press_seen_q <= 1'b0;
							last_press_q <= 32'd0;
						end
						default: begin
							// Control tick.
							if (climb_mode_q == ctsg_pkg::CLIMB_CONT) begin
								thr_q <= 1'b1;
							end else if (climb_mode_q == ctsg_pkg::CLIMB_STEP) begin
								if (expired || remaining[32] || remaining == 33'd0) begin
									climb_mode_q <= ctsg_pkg::CLIMB_OFF;
								end else if (!item_q.vs_pos) begin
									thr_q <= 1'b1;
								end else if (cfg.body_mass != 31'd0) begin
									state_q <= S_MDRAG;
								end else begin
									state_q <= S_MSQ;
								end
							end
						end
					endcase
				end
				S_MDRAG:      state_q <= S_DDRAG_GO;
				S_DDRAG_GO:   state_q <= S_DDRAG_WAIT;
				S_DDRAG_WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_MSQ;
					end
				end
				S_MSQ: begin
					state_q <= (decel_q != 64'd0) ? S_DCOAST_GO : S_MLAG;
				end
				S_DCOAST_GO:  state_q <= S_DCOAST_WT;
				S_DCOAST_WT: begin
					if (div_rsp.done) begin
						state_q <= S_MLAG;
					end
				end
				S_MLAG:       state_q <= S_CMP;
				S_CMP: begin
					// Stop when coast plus lag rise covers the distance left.
					if (stop_sum >= {15'd0, rem_q}) begin
						climb_mode_q <= ctsg_pkg::CLIMB_OFF;
						thr_q        <= 1'b0;
					end else begin
						thr_q <= 1'b1;
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/climb_step_throttle_governor.sv
// Top level: configuration registers, front end, back end and the output register.
// Depends on ctsg_pkg, ctsg_front, ctsg_back (which holds ctsg_div).
`default_nettype none

// Climb governor for a multirotor. Each request gives exactly one result. Presses,
// cancels, full resets and ticks outside a step climb go straight from execution to
// the result in the back end. A tick in a step climb short of its target and deadline
// with upward speed runs the stopping test on a shared 32x32 multiplier and a shared
// 64-bit radix-2 divider (drag, then coast if the deceleration is nonzero), skipping
// the drag steps when body_mass is zero. A two-entry request queue lets the input
// keep accepting while the back end works, and an output register holds the result.
// Configuration writes are taken at any time but must only be made while idle.
module climb_step_throttle_governor (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire  [2:0]         cfg_index,
	input  wire  [30:0]        cfg_wdata,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire  [1:0]         mode,
	input  wire  [31:0]        time_ms,
	input  wire  signed [31:0] altitude,
	input  wire  signed [31:0] vertical_speed,
	output logic               out_valid,
	input  wire                out_ready,
	output logic               throttle,
	output logic [1:0]         climb_state
);

	ctsg_pkg::cfg_t    cfg_q;
	ctsg_pkg::item_t   q_head;
	ctsg_pkg::result_t res;
	logic              q_valid;
	logic              q_pop;
	logic              res_valid;
	logic              res_ready;
	logic              out_valid_q;
	ctsg_pkg::result_t out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gravity          <= ctsg_pkg::GRAVITY_RST;
			cfg_q.drag_coefficient <= 31'd0;
			cfg_q.body_mass        <= ctsg_pkg::MASS_RST;
			cfg_q.motor_lag        <= 31'd0;
			cfg_q.double_tap_ms    <= ctsg_pkg::DTAP_RST;
			cfg_q.step_timeout_ms  <= ctsg_pkg::TIMEOUT_RST;
			cfg_q.step_height      <= ctsg_pkg::STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ctsg_pkg::REG_GRAVITY: cfg_q.gravity          <= cfg_wdata;
				ctsg_pkg::REG_DRAG:    cfg_q.drag_coefficient <= cfg_wdata;
				ctsg_pkg::REG_MASS:    cfg_q.body_mass        <= cfg_wdata;
				ctsg_pkg::REG_LAG:     cfg_q.motor_lag        <= cfg_wdata;
				ctsg_pkg::REG_DTAP:    cfg_q.double_tap_ms    <= cfg_wdata[15:0];
				ctsg_pkg::REG_TIMEOUT: cfg_q.step_timeout_ms  <= cfg_wdata[15:0];
				ctsg_pkg::REG_STEP:    cfg_q.step_height      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ctsg_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.time_ms        (time_ms),
		.altitude       (altitude),
		.vertical_speed (vertical_speed),
		.q_valid        (q_valid),
		.q_head         (q_head),
		.q_pop          (q_pop)
	);

	ctsg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// Output register.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	assign out_valid   = out_valid_q;
	assign throttle    = out_q.throttle;
	assign climb_state = out_q.climb_state;

endmodule

`default_nettype wire
